[design/tpct_pkg.sv]
// tpct_pkg: shared types and codes for the tcp passive connection tracker
// no dependencies
`timescale 1ns / 1ps

package tpct_pkg;

  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_SYNRCV = 2'd1;
  localparam logic [1:0] ST_EST    = 2'd2;
  localparam logic [1:0] ST_FINRCV = 2'd3;

  localparam logic [1:0] RK_NONE   = 2'd0;
  localparam logic [1:0] RK_SYNACK = 2'd1;
  localparam logic [1:0] RK_FINACK = 2'd2;
  localparam logic [1:0] RK_ACK    = 2'd3;

  localparam logic REG_LISTEN_PORT = 1'b0;
  localparam logic REG_LOCAL_ADDR  = 1'b1;

  typedef struct packed {
    logic [31:0] client_addr;
    logic [15:0] client_port;
    logic [15:0] target_port;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic        flag_psh;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] window_size;
    logic [15:0] payload_len;
    logic [31:0] fresh_isn;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack_number;
    logic [31:0] reply_dst_addr;
    logic [15:0] reply_dst_port;
    logic [31:0] reply_src_addr;
    logic [15:0] reply_src_port;
    logic [1:0]  new_state;
    logic        message_done;
    logic        dropped;
  } result_t;

endpackage

[design/tpct_if.sv]
// tpct_hdr_if and tpct_res_if: valid/ready channels for header and result words
// depends on tpct_pkg
`timescale 1ns / 1ps

interface tpct_hdr_if;
  logic valid;
  logic ready;
  tpct_pkg::hdr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpct_res_if;
  logic valid;
  logic ready;
  tpct_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tpct_front.sv]
// tpct_front: accepts header words, checks the port, queues them for the back end
// depends on tpct_pkg
`timescale 1ns / 1ps

module tpct_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        listen_port,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpct_pkg::hdr_t     in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output tpct_pkg::hdr_t     q_data,
  output logic               q_port_ok
);

  // two-entry queue of header words with a port-match tag
  tpct_pkg::hdr_t qd [2];
  logic           qok [2];
  logic [1:0]     count;
  logic           wptr;
  logic           rptr;
  logic           push;
  logic           pop;

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_data    = qd[rptr];
  assign q_port_ok = qok[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qd[wptr]  <= in_data;
      qok[wptr] <= (in_data.target_port == listen_port);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("fill count lost a push");

endmodule

[design/tpct_back.sv]
// tpct_back: connection table lookup and update, registered result word
// depends on tpct_pkg
`timescale 1ns / 1ps

module tpct_back #(
  parameter int CONNECTIONS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         listen_port,
  input  logic [31:0]         local_addr,
  input  logic                q_valid,
  output logic                q_ready,
  input  tpct_pkg::hdr_t      q_data,
  input  logic                q_port_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output tpct_pkg::result_t   out_data
);

  localparam int IW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  logic [CONNECTIONS-1:0] ent_valid;
  logic [31:0] ent_addr [CONNECTIONS];
  logic [15:0] ent_port [CONNECTIONS];
  logic [1:0]  ent_state [CONNECTIONS];
  logic [31:0] ent_cseq [CONNECTIONS];
  logic [31:0] ent_sseq [CONNECTIONS];
  logic [15:0] ent_win [CONNECTIONS];

  logic              take;
  logic              hit;
  logic [IW-1:0]     hit_idx;
  logic              free;
  logic [IW-1:0]     free_idx;
  logic [1:0]        st;
  logic [31:0]       seq1;
  logic [31:0]       cseq_sum;
  logic              we;
  logic [IW-1:0]     widx;
  logic              w_key;
  logic [1:0]        w_state;
  logic              w_cseq;
  logic [31:0]       w_cseq_val;
  logic              w_sseq;
  logic [31:0]       w_sseq_val;
  logic              w_win;
  tpct_pkg::result_t res;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  // parallel key match and free-slot search, lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = CONNECTIONS - 1; i >= 0; i--) begin
      if (ent_valid[i] && ent_addr[i] == q_data.client_addr &&
          ent_port[i] == q_data.client_port) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!ent_valid[i] || ent_state[i] == tpct_pkg::ST_CLOSED) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign st       = ent_state[hit_idx];
  assign seq1     = q_data.seq_number + 32'd1;
  assign cseq_sum = ent_cseq[hit_idx] + {16'd0, q_data.payload_len};

  // rule decode
  always_comb begin
    res        = '0;
    we         = 1'b0;
    widx       = hit_idx;
    w_key      = 1'b0;
    w_state    = st;
    w_cseq     = 1'b0;
    w_cseq_val = seq1;
    w_sseq     = 1'b0;
    w_sseq_val = q_data.ack_number;
    w_win      = 1'b0;
    if (!q_port_ok) begin
      res.dropped = 1'b1;
    end else if (q_data.flag_syn && (!hit || st == tpct_pkg::ST_CLOSED)) begin
      if (!hit && !free) begin
        res.dropped = 1'b1;
      end else begin
        we         = 1'b1;
        widx       = hit ? hit_idx : free_idx;
        w_key      = 1'b1;
        w_state    = tpct_pkg::ST_SYNRCV;
        w_cseq     = 1'b1;
        w_sseq     = 1'b1;
        w_sseq_val = q_data.fresh_isn;
        w_win      = 1'b1;
        res.reply_kind       = tpct_pkg::RK_SYNACK;
        res.reply_seq        = q_data.fresh_isn;
        res.reply_ack_number = seq1;
        res.new_state        = tpct_pkg::ST_SYNRCV;
      end
    end else if (!hit) begin
      res.dropped = 1'b1;
    end else if (st == tpct_pkg::ST_SYNRCV && q_data.flag_ack) begin
      we            = 1'b1;
      w_state       = tpct_pkg::ST_EST;
      w_sseq        = 1'b1;
      w_win         = 1'b1;
      res.new_state = tpct_pkg::ST_EST;
    end else if (st == tpct_pkg::ST_EST && q_data.flag_fin) begin
      we                   = 1'b1;
      w_state              = tpct_pkg::ST_FINRCV;
      w_cseq               = 1'b1;
      res.reply_kind       = tpct_pkg::RK_FINACK;
      res.reply_seq        = ent_sseq[hit_idx];
      res.reply_ack_number = seq1;
      res.new_state        = tpct_pkg::ST_FINRCV;
    end else if (st == tpct_pkg::ST_FINRCV && q_data.flag_ack) begin
      we            = 1'b1;
      w_state       = tpct_pkg::ST_CLOSED;
      w_sseq        = 1'b1;
      res.new_state = tpct_pkg::ST_CLOSED;
    end else if (st == tpct_pkg::ST_EST) begin
      we                   = 1'b1;
      w_cseq             = 1'b1;
      w_cseq_val           = cseq_sum;
      res.reply_kind       = tpct_pkg::RK_ACK;
      res.reply_seq        = ent_sseq[hit_idx];
      res.reply_ack_number = cseq_sum;
      res.new_state        = tpct_pkg::ST_EST;
      res.message_done     = q_data.flag_psh;
    end else begin
      res.new_state = st;
    end
    if (res.reply_kind != tpct_pkg::RK_NONE) begin
      res.reply_dst_addr = q_data.client_addr;
      res.reply_dst_port = q_data.client_port;
      res.reply_src_addr = local_addr;
      res.reply_src_port = listen_port;
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (take && we) begin
      ent_state[widx] <= w_state;
      if (w_key) begin
        ent_addr[widx] <= q_data.client_addr;
        ent_port[widx] <= q_data.client_port;
      end
      if (w_cseq) ent_cseq[widx] <= w_cseq_val;
      if (w_sseq) ent_sseq[widx] <= w_sseq_val;
      if (w_win) ent_win[widx] <= q_data.window_size;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (take && we) begin
      ent_valid[widx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data <= res;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result lost");
  assert property (@(posedge clk) disable iff (rst)
    (take && !q_port_ok) |-> !we)
    else $error("wrong-port word changed the table");
  assert property (@(posedge clk) disable iff (rst)
    (take && we && w_key) |=> ent_valid[$past(widx)])
    else $error("new connection not marked valid");
  assert property (@(posedge clk) disable iff (rst)
    (take && we && w_win) |=> (ent_win[$past(widx)] == $past(q_data.window_size)))
    else $error("window not stored");

endmodule

[design/tcp_passive_connection_tracker_unit.sv]
// tcp_passive_connection_tracker_unit: top level of the connection tracker
// depends on tpct_pkg, tpct_if, tpct_front, tpct_back
`timescale 1ns / 1ps

// One header word in gives one result word out. A word is taken each cycle
// while the output is drained; the header passes a two-word queue (front,
// port check) and then a stage that matches the key against all
// CONNECTIONS entries in parallel, updates the table and registers the result.
// No clearing pass is needed after reset: entry valid bits clear at once.
module tcp_passive_connection_tracker_unit #(
  parameter int CONNECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  tpct_hdr_if.sink    hdr,
  tpct_res_if.source  res
);

  logic [15:0]    listen_port;
  logic [31:0]    local_addr;
  logic           q_valid;
  logic           q_ready;
  logic           q_port_ok;
  tpct_pkg::hdr_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port <= '0;
      local_addr  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpct_pkg::REG_LISTEN_PORT: listen_port <= cfg_data[15:0];
        tpct_pkg::REG_LOCAL_ADDR:  local_addr  <= cfg_data;
        default: ;
      endcase
    end
  end

  tpct_front u_front (
    .clk, .rst, .listen_port,
    .in_valid (hdr.valid), .in_ready (hdr.ready), .in_data (hdr.data),
    .q_valid, .q_ready, .q_data, .q_port_ok
  );

  tpct_back #(.CONNECTIONS(CONNECTIONS)) u_back (
    .clk, .rst, .listen_port, .local_addr,
    .q_valid, .q_ready, .q_data, .q_port_ok,
    .out_valid (res.valid), .out_ready (res.ready), .out_data (res.data)
  );

endmodule

[tb/tcp_passive_connection_tracker_unit_test.sv]
// tcp_passive_connection_tracker_unit_test: drives tcp header words through the tracker
// and checks each result word against a tracker model kept here; needs tpct_pkg, tpct_if
`timescale 1ns / 1ps

module tcp_passive_connection_tracker_unit_test;

  localparam int CONNS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = tpct_pkg::REG_LISTEN_PORT;
  logic [31:0] cfg_data = '0;

  tpct_hdr_if hdr ();
  tpct_res_if res ();

  tcp_passive_connection_tracker_unit #(.CONNECTIONS(CONNS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .hdr(hdr.sink), .res(res.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tracker model state
  logic [15:0] m_listen_port;
  logic [31:0] m_local_addr;
  logic        t_valid [CONNS];
  logic [31:0] t_addr [CONNS];
  logic [15:0] t_port [CONNS];
  logic [1:0]  t_state [CONNS];
  logic [31:0] t_cseq [CONNS];
  logic [31:0] t_sseq [CONNS];
  logic [15:0] t_win [CONNS];

  tpct_pkg::hdr_t    pending_hdrs[$];
  tpct_pkg::result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int syn_count = 0;
  int drop_count = 0;

  // clients used by the random part, so most traffic hits live entries
  logic [31:0] pool_addr [24];
  logic [15:0] pool_port [24];

  function automatic tpct_pkg::result_t reply_word(logic [1:0] kind, logic [31:0] rseq,
                                                   logic [31:0] rack, logic [31:0] daddr,
                                                   logic [15:0] dport, logic [1:0] st,
                                                   logic done, logic drop);
    tpct_pkg::result_t r;
    r = '0;
    r.reply_kind = kind;
    if (kind != tpct_pkg::RK_NONE) begin
      r.reply_seq = rseq;
      r.reply_ack_number = rack;
      r.reply_dst_addr = daddr;
      r.reply_dst_port = dport;
      r.reply_src_addr = m_local_addr;
      r.reply_src_port = m_listen_port;
    end
    r.new_state = st;
    r.message_done = done;
    r.dropped = drop;
    return r;
  endfunction

  // advance the tracker model by one header and return its result
  function automatic tpct_pkg::result_t track_header(tpct_pkg::hdr_t h);
    int hit;
    int slot;
    logic [1:0] st;
    hit = -1;
    slot = -1;
    if (h.target_port != m_listen_port)
      return reply_word(tpct_pkg::RK_NONE, '0, '0, '0, '0, tpct_pkg::ST_CLOSED,
                        1'b0, 1'b1);
    for (int i = 0; i < CONNS; i++)
      if (hit < 0 && t_valid[i] && t_addr[i] == h.client_addr &&
          t_port[i] == h.client_port)
        hit = i;
    if (h.flag_syn && (hit < 0 || t_state[hit] == tpct_pkg::ST_CLOSED)) begin
      slot = hit;
      if (slot < 0)
        for (int i = 0; i < CONNS; i++)
          if (slot < 0 && (!t_valid[i] || t_state[i] == tpct_pkg::ST_CLOSED)) slot = i;
      if (slot < 0)
        return reply_word(tpct_pkg::RK_NONE, '0, '0, '0, '0, tpct_pkg::ST_CLOSED,
                          1'b0, 1'b1);
      t_valid[slot] = 1'b1;
      t_addr[slot] = h.client_addr;
      t_port[slot] = h.client_port;
      t_state[slot] = tpct_pkg::ST_SYNRCV;
      t_cseq[slot] = h.seq_number + 32'd1;
      t_sseq[slot] = h.fresh_isn;
      t_win[slot] = h.window_size;
      return reply_word(tpct_pkg::RK_SYNACK, h.fresh_isn, h.seq_number + 32'd1,
                        h.client_addr, h.client_port, tpct_pkg::ST_SYNRCV, 1'b0, 1'b0);
    end
    if (hit < 0)
      return reply_word(tpct_pkg::RK_NONE, '0, '0, '0, '0, tpct_pkg::ST_CLOSED,
                        1'b0, 1'b1);
    st = t_state[hit];
    if (st == tpct_pkg::ST_SYNRCV && h.flag_ack) begin
      t_state[hit] = tpct_pkg::ST_EST;
      t_sseq[hit] = h.ack_number;
      t_win[hit] = h.window_size;
      return reply_word(tpct_pkg::RK_NONE, '0, '0, '0, '0, tpct_pkg::ST_EST, 1'b0, 1'b0);
    end else if (st == tpct_pkg::ST_EST && h.flag_fin) begin
      t_state[hit] = tpct_pkg::ST_FINRCV;
      t_cseq[hit] = h.seq_number + 32'd1;
      return reply_word(tpct_pkg::RK_FINACK, t_sseq[hit], h.seq_number + 32'd1,
                        h.client_addr, h.client_port, tpct_pkg::ST_FINRCV, 1'b0, 1'b0);
    end else if (st == tpct_pkg::ST_FINRCV && h.flag_ack) begin
      t_state[hit] = tpct_pkg::ST_CLOSED;
      t_sseq[hit] = h.ack_number;
      return reply_word(tpct_pkg::RK_NONE, '0, '0, '0, '0, tpct_pkg::ST_CLOSED,
                        1'b0, 1'b0);
    end else if (st == tpct_pkg::ST_EST) begin
      t_cseq[hit] = t_cseq[hit] + {16'd0, h.payload_len};
      return reply_word(tpct_pkg::RK_ACK, t_sseq[hit], t_cseq[hit], h.client_addr,
                        h.client_port, tpct_pkg::ST_EST, h.flag_psh, 1'b0);
    end
    return reply_word(tpct_pkg::RK_NONE, '0, '0, '0, '0, st, 1'b0, 1'b0);
  endfunction

  function automatic tpct_pkg::hdr_t random_header();
    tpct_pkg::hdr_t h;
    logic [223:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    h = bits[$bits(tpct_pkg::hdr_t)-1:0];
    return h;
  endfunction

  // well-formed segment from a pool client with random content
  function automatic tpct_pkg::hdr_t pool_header(int c, int kind);
    tpct_pkg::hdr_t h;
    h = random_header();
    h.client_addr = pool_addr[c];
    h.client_port = pool_port[c];
    h.target_port = m_listen_port;
    h.flag_syn = 1'b0;
    h.flag_ack = 1'b0;
    h.flag_fin = 1'b0;
    h.payload_len = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
                                                   16'($urandom_range(0, 1460));
    case (kind)
      0: h.flag_syn = 1'b1;
      1: h.flag_ack = 1'b1;
      2: begin
        h.flag_ack = 1'b1;
        h.flag_fin = 1'b1;
      end
      default: h.flag_ack = 1'($urandom_range(0, 1));
    endcase
    return h;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tpct_pkg::REG_LISTEN_PORT) m_listen_port = value[15:0];
    else m_local_addr = value;
  endtask

  task automatic wait_drained();
    while (pending_hdrs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  bit sender_hold = 1'b0;
  initial begin
    hdr.valid = 1'b0;
    hdr.data = '0;
  end
  always @(posedge clk) begin
    if (rst) begin
      hdr.valid <= 1'b0;
    end else begin
      if (hdr.valid && hdr.ready) begin
        expected_results.insert(expected_results.size(), track_header(hdr.data));
        void'(pending_hdrs.pop_front());
      end
      if (!hdr.valid || hdr.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          hdr.valid <= 1'b0;
        end else if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          hdr.valid <= 1'b0;
        end else if (!sender_hold && pending_hdrs.size() > 0) begin
          burst_left <= burst_left - 1;
          hdr.valid <= 1'b1;
          hdr.data <= pending_hdrs[0];
        end else begin
          hdr.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stall pattern and result check
  int stall_phase = 0;
  initial res.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 < 128) res.ready <= 1'b1;
      else res.ready <= ((stall_phase % 7) != 3) && ($urandom_range(0, 3) != 0);
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          tpct_pkg::result_t e;
          tpct_pkg::result_t a;
          e = expected_results.pop_front();
          a = res.data;
          results_seen++;
          if (e.dropped) drop_count++;
          if (e.reply_kind == tpct_pkg::RK_SYNACK) syn_count++;
          if (a.reply_kind !== e.reply_kind) begin
            $error("reply_kind exp %0d got %0d", e.reply_kind, a.reply_kind); errors++; end
          if (a.reply_seq !== e.reply_seq) begin
            $error("reply_seq exp %h got %h", e.reply_seq, a.reply_seq); errors++; end
          if (a.reply_ack_number !== e.reply_ack_number) begin
            $error("reply_ack_number exp %h got %h", e.reply_ack_number,
                   a.reply_ack_number); errors++; end
          if (a.reply_dst_addr !== e.reply_dst_addr) begin
            $error("reply_dst_addr exp %h got %h", e.reply_dst_addr, a.reply_dst_addr);
            errors++; end
          if (a.reply_dst_port !== e.reply_dst_port) begin
            $error("reply_dst_port exp %h got %h", e.reply_dst_port, a.reply_dst_port);
            errors++; end
          if (a.reply_src_addr !== e.reply_src_addr) begin
            $error("reply_src_addr exp %h got %h", e.reply_src_addr, a.reply_src_addr);
            errors++; end
          if (a.reply_src_port !== e.reply_src_port) begin
            $error("reply_src_port exp %h got %h", e.reply_src_port, a.reply_src_port);
            errors++; end
          if (a.new_state !== e.new_state) begin
            $error("new_state exp %0d got %0d", e.new_state, a.new_state); errors++; end
          if (a.message_done !== e.message_done) begin
            $error("message_done exp %0d got %0d", e.message_done, a.message_done);
            errors++; end
          if (a.dropped !== e.dropped) begin
            $error("dropped exp %0d got %0d", e.dropped, a.dropped); errors++; end
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (hdr.valid && hdr.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else if (pending_hdrs.size() != 0 || expected_results.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_hdr(tpct_pkg::hdr_t h);
    pending_hdrs.insert(pending_hdrs.size(), h);
  endtask

  task automatic load_directed();
    tpct_pkg::hdr_t h;
    // syn, handshake ack, data with psh, data without, fin, final ack
    h = pool_header(0, 0); h.seq_number = 32'hFFFF_FFFF; h.fresh_isn = 32'hFFFF_FFFF;
    queue_hdr(h);
    h = pool_header(0, 1); h.ack_number = 32'hFFFF_FFFF; queue_hdr(h);
    h = pool_header(0, 3); h.flag_ack = 1'b1; h.flag_psh = 1'b1; h.payload_len = 16'hFFFF;
    queue_hdr(h);
    h = pool_header(0, 3); h.flag_psh = 1'b0; h.payload_len = 16'd0; queue_hdr(h);
    h = pool_header(0, 2); h.seq_number = 32'hFFFF_FFFF; queue_hdr(h);
    h = pool_header(0, 0); queue_hdr(h);  // syn in fin received: no rule
    h = pool_header(0, 1); queue_hdr(h);
    h = pool_header(0, 3); h.flag_ack = 1'b0; queue_hdr(h);  // closed, no syn
    // wrong port and unknown client
    h = pool_header(1, 0); h.target_port = ~m_listen_port; queue_hdr(h);
    h = pool_header(1, 1); queue_hdr(h);
    // syn on state 1 and non-ack on state 1
    h = pool_header(1, 0); queue_hdr(h);
    h = pool_header(1, 0); queue_hdr(h);
    h = pool_header(1, 3); h.flag_ack = 1'b0; queue_hdr(h);
    // reuse of the closed entry of client 0 by a new client
    h = pool_header(20, 0); queue_hdr(h);
    // fill the rest of the table, then one syn too many
    for (int c = 2; c < CONNS; c++) begin
      h = pool_header(c, 0); queue_hdr(h);
    end
    h = pool_header(21, 0); queue_hdr(h);  // table full
  endtask

  task automatic load_random(int count);
    int c;
    int r;
    tpct_pkg::hdr_t h;
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(0, 23);
      r = $urandom_range(0, 99);
      if (r < 8) h = random_header();
      else if (r < 12) begin
        h = pool_header(c, $urandom_range(0, 3)); h.target_port = 16'($urandom);
      end else if (r < 30) h = pool_header(c, 0);
      else if (r < 50) h = pool_header(c, 1);
      else if (r < 62) h = pool_header(c, 2);
      else begin
        h = pool_header(c, 3); h.flag_psh = 1'($urandom_range(0, 1));
        h.flag_syn = ($urandom_range(0, 9) == 0);
      end
      queue_hdr(h);
    end
  endtask

  initial begin
    for (int i = 0; i < CONNS; i++) t_valid[i] = 1'b0;
    m_listen_port = '0;
    m_local_addr = '0;
    for (int c = 0; c < 24; c++) begin
      pool_addr[c] = $urandom;
      pool_port[c] = 16'($urandom);
    end
    pool_addr[0] = 32'hFFFF_FFFF; pool_port[0] = 16'hFFFF;
    pool_addr[1] = 32'h0; pool_port[1] = 16'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // phase one: port and address at their upper extremes
    write_reg(tpct_pkg::REG_LISTEN_PORT, 32'h0000_FFFF);
    write_reg(tpct_pkg::REG_LOCAL_ADDR, 32'hFFFF_FFFF);
    load_directed();
    wait_drained();

    // phase two: zero extremes, random traffic with a full drain midway
    write_reg(tpct_pkg::REG_LISTEN_PORT, 32'h0);
    write_reg(tpct_pkg::REG_LOCAL_ADDR, 32'h0);
    load_random(500);
    while (pending_hdrs.size() > 250) @(posedge clk);
    sender_hold = 1'b1;
    while (expected_results.size() != 0 || hdr.valid) @(posedge clk);
    sender_hold = 1'b0;
    wait_drained();

    // phase three: random settings
    write_reg(tpct_pkg::REG_LISTEN_PORT, $urandom);
    write_reg(tpct_pkg::REG_LOCAL_ADDR, $urandom);
    load_random(1000);
    wait_drained();

    $display("covered %0d result words: %0d syn+ack replies, %0d dropped segments",
             results_seen, syn_count, drop_count);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[tcp_passive_connection_tracker_unit.f]
design/tpct_pkg.sv
design/tpct_if.sv
design/tpct_front.sv
design/tpct_back.sv
design/tcp_passive_connection_tracker_unit.sv
tb/tcp_passive_connection_tracker_unit_test.sv
